>>> sv/bpe_pkg.sv
// shared types, codes and limits for the bacnet primitive encoder
package bpe_pkg;

	// packed word widths on the stream ports, rounded up to whole bytes
	localparam int IN_W  = 184;
	localparam int OUT_W = 88;

	// requested primitive kind
	typedef enum logic [3:0] {
		OP_NULL       = 4'd0,
		OP_BOOL       = 4'd1,
		OP_UNS        = 4'd2,
		OP_SIGNED     = 4'd3,
		OP_REAL       = 4'd4,
		OP_DOUBLE     = 4'd5,
		OP_ENUM       = 4'd6,
		OP_DATE       = 4'd7,
		OP_TIME       = 4'd8,
		OP_OID        = 4'd9,
		OP_CTX_UNS    = 4'd10,
		OP_CTX_ENUM   = 4'd11,
		OP_CTX_SIGNED = 4'd12,
		OP_CTX_BOOL   = 4'd13,
		OP_OPEN       = 4'd14,
		OP_CLOSE      = 4'd15
	} op_t;

	// result status
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_BAD  = 2'd1,
		ST_TAG  = 2'd2,
		ST_ROOM = 2'd3
	} status_t;

	// application tag numbers
	localparam logic [3:0] TAG_NULL   = 4'd0;
	localparam logic [3:0] TAG_BOOL   = 4'd1;
	localparam logic [3:0] TAG_UNS    = 4'd2;
	localparam logic [3:0] TAG_SIGNED = 4'd3;
	localparam logic [3:0] TAG_REAL   = 4'd4;
	localparam logic [3:0] TAG_DOUBLE = 4'd5;
	localparam logic [3:0] TAG_ENUM   = 4'd9;
	localparam logic [3:0] TAG_DATE   = 4'd10;
	localparam logic [3:0] TAG_TIME   = 4'd11;
	localparam logic [3:0] TAG_OID    = 4'd12;

	// lvt codes for opening and closing tags, and the extended length marker
	localparam logic [2:0] LVT_OPEN    = 3'd6;
	localparam logic [2:0] LVT_CLOSE   = 3'd7;
	localparam logic [2:0] LVT_EXT_LEN = 3'd5;

	// range limits
	localparam logic [30:0] REAL_INF     = 31'h7F800000;
	localparam logic [62:0] DOUBLE_INF   = 63'h7FF0000000000000;
	localparam logic [15:0] YEAR_MIN     = 16'd1900;
	localparam logic [15:0] YEAR_MAX     = 16'd2154;
	localparam logic [15:0] YEAR_ANY     = 16'hFFFF;
	localparam logic [7:0]  FIELD_ANY    = 8'hFF;
	localparam logic [7:0]  TAG_RESERVED = 8'hFF;
	localparam logic [7:0]  TAG_EXT_MIN  = 8'd15;
	localparam logic [15:0] OTYPE_MAX    = 16'd1023;
	localparam logic [31:0] OINST_MAX    = 32'h003FFFFF;

	// input word, first field in the lowest bits
	typedef struct packed {
		logic [3:0]  pad;
		logic [7:0]  space_left;
		logic [31:0] object_instance;
		logic [15:0] object_type;
		logic [7:0]  hundredths;
		logic [7:0]  weekday_or_second;
		logic [7:0]  day_or_minute;
		logic [7:0]  month_or_hour;
		logic [15:0] year;
		logic [63:0] value;
		logic [7:0]  tag_number;
		logic [3:0]  operation;
	} in_item_t;

	// result word, first field in the lowest bits
	typedef struct packed {
		logic [1:0]  pad;
		status_t     status;
		logic [3:0]  octet_count;
		logic [63:0] encoded_tail;
		logic [15:0] encoded_head;
	} out_item_t;

endpackage

>>> sv/bacnet_primitive_encoder_core.sv
// top level: bacnet primitive encoder, input register, encoder and result register
//
//  channel   dir  width  contents
//  s_*       in   184    one request word (operation .. space_left)
//  m_*       out  88     one encoding word (head, tail, count, status)
//
// one word per cycle sustained while m_tready is high; a result passes through
// the input register, then the result register after the encoder logic.
// arst_n clears both stage valid flags; payload registers are not reset.
// a stall on m_tready holds the result register, and the input register
// keeps accepting until it too is full, so s_tready drops once it holds a word.
module bacnet_primitive_encoder_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// operation, tag_number, value, year, month_or_hour, day_or_minute,
	// weekday_or_second, hundredths, object_type, object_instance, space_left, pad
	input  logic [bpe_pkg::IN_W-1:0]       s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// encoded_head, encoded_tail, octet_count, status, pad
	output logic [bpe_pkg::OUT_W-1:0]      m_tdata
);
	import bpe_pkg::*;

	in_item_t  in_s1;
	logic      v_s1;
	out_item_t enc_res;
	out_item_t out_s2;
	logic      v_s2;
	logic      adv2;
	logic      adv1;

	// pipeline flow control
	assign adv2     = !v_s2 || m_tready;
	assign adv1     = v_s1 && adv2;
	assign s_tready = !v_s1 || adv2;

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_s1 <= in_item_t'(s_tdata);
		end
	end

	bpe_encode u_encode (
		.item (in_s1),
		.res  (enc_res)
	);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (adv1) begin
			out_s2 <= enc_res;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = out_s2;

	// an accepted word lands in the input register
	a_in_capture: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted word not held in input register");

	// a word that moves on lands in the result register
	a_stage_move: assert property (@(posedge clk) disable iff (!arst_n)
		adv1 |=> v_s2)
		else $error("word lost between stages");

	// errors carry no octets
	a_err_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_s2.status != ST_OK |->
			out_s2.octet_count == 4'd0 && out_s2.encoded_head == 16'd0 &&
			out_s2.encoded_tail == 64'd0)
		else $error("error result carries octets");

	// a good encoding has at least one and at most ten octets
	a_ok_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_s2.status == ST_OK |->
			out_s2.octet_count != 4'd0 && out_s2.octet_count <= 4'd10)
		else $error("bad octet count on good result");

endmodule

>>> sv/bpe_encode.sv
// combinational encoder: checks one request and builds its octets
module bpe_encode (
	input  bpe_pkg::in_item_t  item,
	output bpe_pkg::out_item_t res
);
	import bpe_pkg::*;

	op_t         op;
	logic [31:0] lo;
	logic        bad;
	logic        use_raw;
	logic [2:0]  raw;
	logic [3:0]  apptag;
	logic [3:0]  clen;
	logic [63:0] cont;
	logic [2:0]  uns_len;
	logic [2:0]  sgn_len;
	logic [31:0] sgn_x;
	logic [15:0] year_off;
	logic        year_ok;
	logic        ctx;
	logic [7:0]  tnum;
	logic        ext_tag;
	logic        ext_len;
	logic [2:0]  lvt;
	logic [7:0]  tag_oct;
	logic [7:0]  len_oct;
	logic [23:0] hdr;
	logic [1:0]  hdr_n;
	logic [79:0] body;
	logic [79:0] body_sh;
	logic [79:0] enc;
	logic [3:0]  total;
	status_t     status;

	// left-align the significant octets of a 32-bit word
	function automatic logic [31:0] align_up(input logic [31:0] v, input logic [2:0] len);
		logic [31:0] r;
		unique case (len)
			3'd1:    r = {v[7:0], 24'd0};
			3'd2:    r = {v[15:0], 16'd0};
			3'd3:    r = {v[23:0], 8'd0};
			default: r = v;
		endcase
		return r;
	endfunction

	assign op       = op_t'(item.operation);
	assign lo       = item.value[31:0];
	assign sgn_x    = lo[31] ? ~lo : lo;
	assign year_off = item.year - YEAR_MIN;
	assign year_ok  = (item.year == YEAR_ANY) ||
	                  (item.year >= YEAR_MIN && item.year <= YEAR_MAX);

	// minimal octet count, unsigned
	always_comb begin
		priority if (lo[31:24] != 8'd0) uns_len = 3'd4;
		else if (lo[23:16] != 8'd0)     uns_len = 3'd3;
		else if (lo[15:8] != 8'd0)      uns_len = 3'd2;
		else                            uns_len = 3'd1;
	end

	// minimal octet count, two's complement
	always_comb begin
		priority if (sgn_x[31:23] != 9'd0) sgn_len = 3'd4;
		else if (sgn_x[31:15] != 17'd0)    sgn_len = 3'd3;
		else if (sgn_x[31:7] != 25'd0)     sgn_len = 3'd2;
		else                               sgn_len = 3'd1;
	end

	// per-kind checks and content octets
	always_comb begin
		bad     = 1'b0;
		use_raw = 1'b0;
		raw     = 3'd0;
		apptag  = TAG_NULL;
		clen    = 4'd0;
		cont    = 64'd0;
		unique case (op)
			OP_NULL: begin
				apptag = TAG_NULL;
			end
			OP_BOOL: begin
				apptag  = TAG_BOOL;
				use_raw = 1'b1;
				raw     = {2'b00, lo[0]};
			end
			OP_UNS, OP_ENUM, OP_CTX_UNS, OP_CTX_ENUM: begin
				apptag = (op == OP_UNS) ? TAG_UNS : TAG_ENUM;
				bad    = (item.value[63:32] != 32'd0);
				clen   = {1'b0, uns_len};
				cont   = {align_up(lo, uns_len), 32'd0};
			end
			OP_SIGNED, OP_CTX_SIGNED: begin
				apptag = TAG_SIGNED;
				clen   = {1'b0, sgn_len};
				cont   = {align_up(lo, sgn_len), 32'd0};
			end
			OP_REAL: begin
				apptag = TAG_REAL;
				bad    = (lo[30:0] > REAL_INF);
				clen   = 4'd4;
				cont   = {lo, 32'd0};
			end
			OP_DOUBLE: begin
				apptag = TAG_DOUBLE;
				bad    = (item.value[62:0] > DOUBLE_INF);
				clen   = 4'd8;
				cont   = item.value;
			end
			OP_DATE: begin
				apptag = TAG_DATE;
				bad    = !year_ok ||
				         !((item.month_or_hour >= 8'd1 && item.month_or_hour <= 8'd14) ||
				           item.month_or_hour == FIELD_ANY) ||
				         !((item.day_or_minute >= 8'd1 && item.day_or_minute <= 8'd34) ||
				           item.day_or_minute == FIELD_ANY) ||
				         !((item.weekday_or_second >= 8'd1 && item.weekday_or_second <= 8'd7) ||
				           item.weekday_or_second == FIELD_ANY);
				clen   = 4'd4;
				cont   = {((item.year == YEAR_ANY) ? FIELD_ANY : year_off[7:0]),
				          item.month_or_hour, item.day_or_minute,
				          item.weekday_or_second, 32'd0};
			end
			OP_TIME: begin
				apptag = TAG_TIME;
				bad    = !(item.month_or_hour <= 8'd23 || item.month_or_hour == FIELD_ANY) ||
				         !(item.day_or_minute <= 8'd59 || item.day_or_minute == FIELD_ANY) ||
				         !(item.weekday_or_second <= 8'd59 ||
				           item.weekday_or_second == FIELD_ANY) ||
				         !(item.hundredths <= 8'd99 || item.hundredths == FIELD_ANY);
				clen   = 4'd4;
				cont   = {item.month_or_hour, item.day_or_minute, item.weekday_or_second,
				          item.hundredths, 32'd0};
			end
			OP_OID: begin
				apptag = TAG_OID;
				bad    = (item.object_type > OTYPE_MAX) || (item.object_instance > OINST_MAX);
				clen   = 4'd4;
				cont   = {item.object_type[9:0], item.object_instance[21:0], 32'd0};
			end
			OP_CTX_BOOL: begin
				clen = 4'd1;
				cont = {7'd0, lo[0], 56'd0};
			end
			OP_OPEN: begin
				use_raw = 1'b1;
				raw     = LVT_OPEN;
			end
			OP_CLOSE: begin
				use_raw = 1'b1;
				raw     = LVT_CLOSE;
			end
		endcase
	end

	// tag octet with optional extended tag number and extended length
	assign ctx     = (item.operation >= OP_CTX_UNS);
	assign tnum    = ctx ? item.tag_number : {4'd0, apptag};
	assign ext_tag = (tnum >= TAG_EXT_MIN);
	assign ext_len = !use_raw && (clen >= 4'd5);
	assign lvt     = use_raw ? raw : (ext_len ? LVT_EXT_LEN : clen[2:0]);
	assign tag_oct = {(ext_tag ? 4'hF : tnum[3:0]), ctx, lvt};
	assign len_oct = ext_len ? {4'd0, clen} : 8'd0;
	assign hdr     = ext_tag ? {tag_oct, tnum, len_oct} : {tag_oct, len_oct, 8'd0};
	assign hdr_n   = 2'd1 + {1'b0, ext_tag} + {1'b0, ext_len};

	// content placed right after the header octets
	assign body = {cont, 16'd0};
	always_comb begin
		unique case (hdr_n)
			2'd2:    body_sh = body >> 16;
			2'd3:    body_sh = body >> 24;
			default: body_sh = body >> 8;
		endcase
	end

	assign enc   = {hdr, 56'd0} | body_sh;
	assign total = {2'b00, hdr_n} + clen;

	// error priority: value, reserved tag, room
	always_comb begin
		priority if (bad)                                  status = ST_BAD;
		else if (ctx && item.tag_number == TAG_RESERVED)   status = ST_TAG;
		else if ({4'd0, total} > item.space_left)          status = ST_ROOM;
		else                                               status = ST_OK;
	end

	// result word, cleared on any error
	always_comb begin
		res        = '0;
		res.status = status;
		if (status == ST_OK) begin
			res.encoded_head = enc[79:64];
			res.encoded_tail = enc[63:0];
			res.octet_count  = total;
		end
	end

endmodule
